// ===== sv/pcmfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcmfc_pkg
// Format codes, register indexes, pipeline word type and helper functions
// for the PCM sample format converter.
// ----------------------------------------------------------------------------
package pcmfc_pkg;

    // sample format codes
    localparam logic [2:0] FMT_U8  = 3'd0;
    localparam logic [2:0] FMT_S16 = 3'd1;
    localparam logic [2:0] FMT_S32 = 3'd2;
    localparam logic [2:0] FMT_FLT = 3'd3;
    localparam logic [2:0] FMT_DBL = 3'd4;

    // configuration register indexes
    localparam logic CFG_SOURCE = 1'b0;
    localparam logic CFG_TARGET = 1'b1;

    // one word as it travels down the pipeline
    typedef struct packed {
        logic [2:0]         tgt;   // target format
        logic               done;  // result already final
        logic [63:0]        res;   // final result when done
        logic               sgn;   // sign of the value
        logic signed [12:0] expo;  // exponent of mantissa bit 52 (or scaled)
        logic [52:0]        man;   // mantissa / working magnitude
        logic [5:0]         lz;    // leading zero count
        logic               rnd;   // round-up decision
        logic               inf;   // overflowed to infinity
    } t_stage;

    // width mask of a format
    function automatic logic [63:0] fmt_mask(input logic [2:0] f);
        logic [63:0] m;
        m = 64'hFFFF_FFFF_FFFF_FFFF;
        if (f == FMT_U8) m = 64'h0000_0000_0000_00FF;
        else if (f == FMT_S16) m = 64'h0000_0000_0000_FFFF;
        else if (f == FMT_S32 || f == FMT_FLT) m = 64'h0000_0000_FFFF_FFFF;
        return m;
    endfunction

    // left-aligned 32-bit word to integer code of the target
    function automatic logic [63:0] word_to_int(input logic [2:0] f, input logic [31:0] w);
        logic [63:0] r;
        r = {32'd0, w};
        if (f == FMT_U8) r = {56'd0, w[31:24] ^ 8'h80};
        else if (f == FMT_S16) r = {48'd0, w[31:16]};
        return r;
    endfunction

    // leading zero count of a 53-bit mantissa
    function automatic logic [5:0] lzc53(input logic [52:0] m);
        logic [5:0] n;
        n = 6'd53;
        for (int i = 0; i < 53; i++) begin
            if (m[i]) n = 6'(52 - i);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== sv/pcm_sample_format_converter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_sample_format_converter_unit
// Converts PCM samples between u8, s16, s32, single and double.
// ----------------------------------------------------------------------------
//  channel     | direction | signals
//  ------------+-----------+-----------------------------------------------
//  sample in   | in        | i_sample_valid, o_sample_ready, i_sample_bits
//  result out  | out       | o_converted_valid, i_converted_ready,
//              |           | o_converted_bits
//  config      | in        | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
//
//  Seven register stages: unpack, leading zero count, normalise, single
//  denormalise, single round, integer shift, integer round. One word is
//  taken in every cycle in which the output is not stalled.
//  A stalled output freezes all stages together; nothing is dropped.
//  Reset clears the valid bits and sets source s16, target single.
// ----------------------------------------------------------------------------
module pcm_sample_format_converter_unit
    import pcmfc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_sample_valid,
    output logic        o_sample_ready,
    input  wire  [63:0] i_sample_bits,
    output logic        o_converted_valid,
    input  wire         i_converted_ready,
    output logic [63:0] o_converted_bits,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [2:0]  i_cfg_data
);

    logic [2:0] r_src;
    logic [2:0] r_tgt;
    logic [6:0] r_vld;
    logic       en;
    t_stage r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7;
    t_stage n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7;

    // pipeline advance
    assign en                = !r_vld[6] || i_converted_ready;
    assign o_sample_ready    = en;
    assign o_converted_valid = r_vld[6];
    assign o_converted_bits  = r_s7.res;
    assign o_cfg_ready       = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= FMT_S16;
            r_tgt <= FMT_FLT;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SOURCE) r_src <= i_cfg_data;
            else r_tgt <= i_cfg_data;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[5:0], i_sample_valid};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
            r_s6 <= n_s6;
            r_s7 <= n_s7;
        end
    end

    // stage 1: unpack, specials and direct results
    always_comb begin
        logic [63:0] x;
        logic [31:0] w;
        logic [31:0] mag;
        logic        s;
        logic        emax;
        logic        ezero;
        logic        fzero;
        logic [31:0] satw;
        x     = i_sample_bits & fmt_mask(r_src);
        w     = x[31:0];
        mag   = '0;
        s     = 1'b0;
        emax  = 1'b0;
        ezero = 1'b0;
        fzero = 1'b0;
        satw  = '0;
        n_s1  = '0;
        n_s1.tgt  = r_tgt;
        n_s1.done = 1'b1;
        if (r_src == FMT_U8) w = {x[7:0] ^ 8'h80, 24'd0};
        else if (r_src == FMT_S16) w = {x[15:0], 16'd0};
        if (r_src > FMT_DBL || r_tgt > FMT_DBL) begin
            n_s1.res = '0;
        end else if (r_src == r_tgt) begin
            n_s1.res = x;
        end else if (r_src <= FMT_S32) begin
            // integer source
            if (r_tgt <= FMT_S32) begin
                n_s1.res = word_to_int(r_tgt, w);
            end else if (w == 32'd0) begin
                n_s1.res = '0;
            end else begin
                mag = w[31] ? (~w + 32'd1) : w;
                n_s1.done = 1'b0;
                n_s1.sgn  = w[31];
                n_s1.expo = '0;
                n_s1.man  = {mag, 21'd0};
            end
        end else begin
            // float or double source
            if (r_src == FMT_FLT) begin
                s     = x[31];
                emax  = x[30:23] == 8'hFF;
                ezero = x[30:23] == 8'h00;
                fzero = x[22:0] == 23'd0;
                n_s1.man  = {!ezero, x[22:0], 29'd0};
                n_s1.expo = ezero ? -13'sd126 : $signed({5'd0, x[30:23]}) - 13'sd127;
            end else begin
                s     = x[63];
                emax  = x[62:52] == 11'h7FF;
                ezero = x[62:52] == 11'h000;
                fzero = x[51:0] == 52'd0;
                n_s1.man  = {!ezero, x[51:0]};
                n_s1.expo = ezero ? -13'sd1022 : $signed({2'd0, x[62:52]}) - 13'sd1023;
            end
            n_s1.sgn = s;
            satw = s ? 32'h8000_0000 : 32'h7FFF_FFFF;
            if (emax && !fzero) begin
                // not a number
                if (r_tgt == FMT_FLT) n_s1.res = {32'd0, s, 8'hFF, 1'b1, x[50:29]};
                else if (r_tgt == FMT_DBL) n_s1.res = {s, 11'h7FF, 1'b1, x[21:0], 29'd0};
                else n_s1.res = word_to_int(r_tgt, 32'h8000_0000);
            end else if (emax) begin
                // infinity
                if (r_tgt == FMT_FLT) n_s1.res = {32'd0, s, 8'hFF, 23'd0};
                else if (r_tgt == FMT_DBL) n_s1.res = {s, 11'h7FF, 52'd0};
                else n_s1.res = word_to_int(r_tgt, satw);
            end else if (ezero && fzero) begin
                // signed zero
                if (r_tgt == FMT_FLT) n_s1.res = {32'd0, s, 31'd0};
                else if (r_tgt == FMT_DBL) n_s1.res = {s, 63'd0};
                else n_s1.res = word_to_int(r_tgt, 32'd0);
            end else begin
                n_s1.done = 1'b0;
            end
        end
    end

    // stage 2: leading zero count
    always_comb begin
        n_s2 = r_s1;
        n_s2.lz = lzc53(r_s1.man);
    end

    // stage 3: normalise, pack double results
    always_comb begin
        logic signed [12:0] e;
        n_s3 = r_s2;
        e    = '0;
        if (!r_s2.done) begin
            n_s3.man  = r_s2.man << r_s2.lz;
            n_s3.expo = r_s2.expo - $signed({7'd0, r_s2.lz});
            e = n_s3.expo + 13'sd1023;
            if (r_s2.tgt == FMT_DBL) begin
                n_s3.done = 1'b1;
                n_s3.res  = {r_s2.sgn, e[10:0], n_s3.man[51:0]};
            end
        end
    end

    // stage 4: denormalise to single range, find round bit
    always_comb begin
        logic signed [12:0] d;
        logic [4:0]         sh;
        logic [78:0]        wv;
        n_s4 = r_s3;
        d  = -13'sd126 - r_s3.expo;
        sh = '0;
        if (r_s3.expo < -13'sd126) sh = (d > 13'sd26) ? 5'd26 : d[4:0];
        wv = {r_s3.man, 26'd0} >> sh;
        if (!r_s3.done) begin
            n_s4.man  = {29'd0, wv[78:55]};
            n_s4.rnd  = wv[54] & ((|wv[53:0]) | wv[55]);
            n_s4.expo = (sh != 5'd0) ? -13'sd126 : r_s3.expo;
        end
    end

    // stage 5: round to single, pack single results
    always_comb begin
        logic [24:0]        m25;
        logic [23:0]        mant;
        logic signed [12:0] e;
        logic signed [12:0] be;
        n_s5 = r_s4;
        m25  = {1'b0, r_s4.man[23:0]} + {24'd0, r_s4.rnd};
        mant = m25[24] ? m25[24:1] : m25[23:0];
        e    = m25[24] ? r_s4.expo + 13'sd1 : r_s4.expo;
        be   = e + 13'sd127;
        if (!r_s4.done) begin
            n_s5.man  = {29'd0, mant};
            n_s5.expo = e;
            n_s5.inf  = e > 13'sd127;
            if (r_s4.tgt == FMT_FLT) begin
                n_s5.done = 1'b1;
                if (n_s5.inf) n_s5.res = {32'd0, r_s4.sgn, 8'hFF, 23'd0};
                else n_s5.res = {32'd0, r_s4.sgn, mant[23] ? be[7:0] : 8'd0, mant[22:0]};
            end
        end
    end

    // stage 6: scale to integer, saturate large values
    always_comb begin
        logic signed [12:0] k;
        logic signed [12:0] t;
        logic [5:0]         rs;
        logic [66:0]        yv;
        n_s6 = r_s5;
        k = 13'sd31;
        if (r_s5.tgt == FMT_U8) k = 13'sd7;
        else if (r_s5.tgt == FMT_S16) k = 13'sd15;
        t  = 13'sd31 - r_s5.expo - k;
        rs = (t > 13'sd35) ? 6'd35 : t[5:0];
        yv = {r_s5.man[23:0], 8'd0, 35'd0} >> rs;
        if (!r_s5.done) begin
            if (r_s5.inf || r_s5.expo >= 13'sd0) begin
                n_s6.done = 1'b1;
                n_s6.res  = word_to_int(r_s5.tgt,
                                        r_s5.sgn ? 32'h8000_0000 : 32'h7FFF_FFFF);
            end else begin
                n_s6.man = {21'd0, yv[66:35]};
                n_s6.rnd = yv[34] & ((|yv[33:0]) | yv[35]);
            end
        end
    end

    // stage 7: round to integer, clamp, pack
    always_comb begin
        logic [31:0] q;
        logic [31:0] hi;
        logic [31:0] r;
        n_s7 = r_s6;
        hi = 32'h7FFF_FFFF;
        if (r_s6.tgt == FMT_U8) hi = 32'd127;
        else if (r_s6.tgt == FMT_S16) hi = 32'd32767;
        q = r_s6.man[31:0] + {31'd0, r_s6.rnd};
        if (!r_s6.sgn && q > hi) q = hi;
        r = r_s6.sgn ? (~q + 32'd1) : q;
        if (!r_s6.done) begin
            n_s7.done = 1'b1;
            if (r_s6.tgt == FMT_U8) n_s7.res = {56'd0, r[7:0] ^ 8'h80};
            else if (r_s6.tgt == FMT_S16) n_s7.res = {48'd0, r[15:0]};
            else n_s7.res = {32'd0, r};
        end
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb_pcm_sample_format_converter_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pcm_sample_format_converter_unit
// Self-checking bench for the PCM sample format converter. A bit-exact
// software converter (integer and IEEE single/double arithmetic done on raw
// fields) predicts each word. Directed corner samples come first, then
// random samples for every source/target pair, invalid codes and a long
// output hold-off, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_pcm_sample_format_converter_unit;
    import pcmfc_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [2:0]  FMT_UNUSED5 = 3'd5;
    localparam logic [2:0]  FMT_UNUSED7 = 3'd7;
    localparam logic [31:0] SGL_INF     = 32'h7F80_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_sample_valid = 1'b0;
    logic [63:0] i_sample_bits = 64'd0;
    logic        i_converted_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [2:0]  i_cfg_data = 3'd0;
    wire         o_sample_ready;
    wire         o_converted_valid;
    wire  [63:0] o_converted_bits;
    wire         o_cfg_ready;

    logic [63:0] expected_words[$];
    logic [2:0]  src_fmt = FMT_S16;
    logic [2:0]  tgt_fmt = FMT_FLT;
    int          error_count = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int          hold_req = 0;
    bit          sender_busy_mode = 1'b0;

    pcm_sample_format_converter_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_sample_valid    (i_sample_valid),
        .o_sample_ready    (o_sample_ready),
        .i_sample_bits     (i_sample_bits),
        .o_converted_valid (o_converted_valid),
        .i_converted_ready (i_converted_ready),
        .o_converted_bits  (o_converted_bits),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------- prediction ----------------

    // shift right with round to nearest, ties to even
    function automatic logic [63:0] rne_shift(input logic [63:0] m, input int n);
        logic [63:0] q;
        logic [63:0] low;
        if (n <= 0) return m;
        if (n > 64) return 64'd0;
        q = (n >= 64) ? 64'd0 : (m >> n);
        low = m & ((64'd1 << (n - 1)) - 64'd1);
        if (m[n-1] && (low != 0 || q[0])) q = q + 64'd1;
        return q;
    endfunction

    function automatic int msb_index(input logic [63:0] m);
        int p;
        p = -1;
        for (int i = 0; i < 64; i++) begin
            if (m[i]) p = i;
        end
        return p;
    endfunction

    // double narrowed to nearest single
    function automatic logic [31:0] dbl_to_sgl(input logic [63:0] d);
        logic        s;
        logic [10:0] e;
        logic [63:0] mant;
        logic [63:0] mr;
        longint      t;
        int          ex;
        s = d[63];
        e = d[62:52];
        if (e == 11'h7FF) begin
            if (d[51:0] == 0) return {s, SGL_INF[30:0]};
            return {s, 8'hFF, 1'b1, d[50:29]};
        end
        if (e == 0) return {s, 31'd0};
        ex = int'(e) - 1023;
        mant = {11'd0, 1'b1, d[51:0]};
        // subnormal result: a carry into bit 23 gives the least normal
        if (ex < -126) begin
            mr = rne_shift(mant, 29 + (-126 - ex));
            return {s, mr[30:0]};
        end
        mr = rne_shift(mant, 29);
        t = (longint'(ex + 126) << 23) + longint'(mr);
        if (ex > 127 || t >= longint'(SGL_INF)) return {s, SGL_INF[30:0]};
        return {s, t[30:0]};
    endfunction

    // single widened to double, exact; nan made quiet
    function automatic logic [63:0] sgl_to_dbl(input logic [31:0] w);
        logic        s;
        logic [7:0]  e;
        logic [63:0] mant;
        int          p;
        int          ex;
        s = w[31];
        e = w[30:23];
        if (e == 8'hFF) begin
            if (w[22:0] == 0) return {s, 11'h7FF, 52'd0};
            return {s, 11'h7FF, 1'b1, w[21:0], 29'd0};
        end
        if (e == 0) begin
            if (w[22:0] == 0) return {s, 63'd0};
            p = msb_index({41'd0, w[22:0]});
            ex = p - 149;
            mant = {41'd0, w[22:0]} << (52 - p);
            return {s, 11'(ex + 1023), mant[51:0]};
        end
        return {s, 11'(int'(e) - 127 + 1023), w[22:0], 29'd0};
    endfunction

    // left-aligned integer word scaled by 2^-31, to single or double
    function automatic logic [63:0] word_to_real(input logic [31:0] w, input bit dbl);
        logic        s;
        logic [63:0] mag;
        logic [63:0] mr;
        longint      t;
        int          p;
        if (w == 0) return 64'd0;
        s = w[31];
        mag = s ? (64'd0 - {{32{1'b1}}, w}) : {32'd0, w};
        p = msb_index(mag);
        if (dbl) begin
            mr = mag << (52 - p);
            return {s, 11'(p - 31 + 1023), mr[51:0]};
        end
        mr = (p > 23) ? rne_shift(mag, p - 23) : (mag << (23 - p));
        t = (longint'(p - 31 + 126) << 23) + longint'(mr);
        return {32'd0, s, t[30:0]};
    endfunction

    // single scaled to the integer range, rounded and saturated
    function automatic logic [63:0] sgl_to_code(input logic [2:0] f, input logic [31:0] w);
        int          k;
        int          sh;
        longint      lo;
        longint      hi;
        longint      r;
        logic [63:0] mant;
        logic [63:0] mag;
        k = (f == FMT_U8) ? 7 : (f == FMT_S16) ? 15 : 31;
        lo = -(longint'(1) << k);
        hi = (longint'(1) << k) - 1;
        if (w[30:23] == 8'hFF) begin
            r = (w[22:0] != 0 || w[31]) ? lo : hi;
        end else begin
            if (w[30:23] == 0) begin
                mant = {41'd0, w[22:0]};
                sh = -149 + k;
            end else begin
                mant = {40'd0, 1'b1, w[22:0]};
                sh = int'(w[30:23]) - 150 + k;
            end
            if (mant == 0) r = 0;
            else if (sh > 39) r = w[31] ? lo : hi;
            else begin
                mag = (sh >= 0) ? (mant << sh) : rne_shift(mant, -sh);
                r = w[31] ? -longint'(mag) : longint'(mag);
                if (r > hi) r = hi;
                if (r < lo) r = lo;
            end
        end
        if (f == FMT_U8) return {56'd0, 8'(r + 128)};
        if (f == FMT_S16) return {48'd0, 16'(r)};
        return {32'd0, 32'(r)};
    endfunction

    function automatic logic [63:0] format_width_mask(input logic [2:0] f);
        if (f == FMT_U8) return 64'hFF;
        if (f == FMT_S16) return 64'hFFFF;
        if (f == FMT_S32 || f == FMT_FLT) return 64'hFFFF_FFFF;
        return 64'hFFFF_FFFF_FFFF_FFFF;
    endfunction

    function automatic logic [63:0] predict_converted(input logic [2:0] sf,
                                                     input logic [2:0] tf,
                                                     input logic [63:0] raw);
        logic [63:0] x;
        logic [31:0] w;
        logic [31:0] v;
        if (sf > FMT_DBL || tf > FMT_DBL) return 64'd0;
        x = raw & format_width_mask(sf);
        if (sf == tf) return x;
        if (sf <= FMT_S32) begin
            if (sf == FMT_U8) w = {x[7:0] ^ 8'h80, 24'd0};
            else if (sf == FMT_S16) w = {x[15:0], 16'd0};
            else w = x[31:0];
            if (tf == FMT_U8) return {56'd0, w[31:24] ^ 8'h80};
            if (tf == FMT_S16) return {48'd0, w[31:16]};
            if (tf == FMT_S32) return {32'd0, w};
            return word_to_real(w, tf == FMT_DBL);
        end
        v = (sf == FMT_DBL) ? dbl_to_sgl(x) : x[31:0];
        if (tf == FMT_FLT) return {32'd0, v};
        if (tf == FMT_DBL) return sgl_to_dbl(v);
        return sgl_to_code(tf, v);
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [63:0] random_sample(input logic [2:0] f);
        logic [63:0] r;
        int          kind;
        r = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        if (f == FMT_FLT) begin
            if (kind < 5) r[30:23] = 8'($urandom_range(100, 165));
            else if (kind == 5) r[30:0] = {8'hFF, 23'($urandom_range(0, 1) * $urandom)};
            else if (kind == 6) r[30:23] = 8'd0;
            // clear low mantissa bits to land on rounding ties
            if (kind == 7 || kind == 4) r[12:0] = 13'd0;
        end else if (f == FMT_DBL) begin
            if (kind < 4) r[62:52] = 11'($urandom_range(1023 - 40, 1023 + 45));
            else if (kind == 4) r[62:52] = 11'($urandom_range(1023 - 152, 1023 - 124));
            else if (kind == 5) r[62:52] = 11'($urandom_range(1023 + 126, 1023 + 129));
            else if (kind == 6) r[62:0] = {11'h7FF, 52'($urandom_range(0, 1) * $urandom)};
            else if (kind == 7) r[62:52] = 11'd0;
            if (kind == 3 || kind == 4 || kind == 5)
                r[28:0] = 29'({1'b1, 28'd0} * $urandom_range(0, 1));
        end
        return r;
    endfunction

    function automatic int draw_gap();
        if (sender_busy_mode) return 0;
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
    endfunction

    // send one sample word and record its expected result
    task automatic send_sample(input logic [63:0] x);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample_bits <= x;
        do @(posedge i_clk); while (!o_sample_ready);
        expected_words.push_back(predict_converted(src_fmt, tgt_fmt, x));
    endtask

    // let the pipeline empty out before touching the registers
    task automatic drain();
        i_sample_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [2:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SOURCE) src_fmt = value;
        else tgt_fmt = value;
    endtask

    task automatic set_formats(input logic [2:0] sf, input logic [2:0] tf);
        drain();
        write_reg(CFG_SOURCE, sf);
        write_reg(CFG_TARGET, tf);
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_formats();
        send_sample(64'h0000_0000_0000_8000);
        send_sample(64'h0000_0000_0000_7FFF);
        send_sample(64'hFFFF_FFFF_FFFF_0001);
    endtask

    task automatic test_float_to_int_corners();
        set_formats(FMT_FLT, FMT_S16);
        send_sample(64'h0000_0000_7FC0_0000);
        send_sample(64'h0000_0000_FF80_0000);
        send_sample(64'hFFFF_FFFF_7F80_0000);
        send_sample(64'h0000_0000_3F80_0000);
        send_sample(64'h0000_0000_BF80_0000);
        send_sample(64'h0000_0000_3780_0000);
        send_sample(64'h0000_0000_3840_0000);
        send_sample(64'h0000_0000_38A0_0000);
        send_sample(64'h0000_0000_0000_0001);
    endtask

    task automatic test_double_corners();
        set_formats(FMT_DBL, FMT_FLT);
        send_sample(64'h7FF8_0000_0000_0001);
        send_sample(64'h47F0_0000_0000_0000);
        send_sample(64'h3690_0000_0000_0000);
        send_sample(64'h36A0_0000_0000_0001);
        send_sample(64'h8000_0000_0000_0000);
        set_formats(FMT_DBL, FMT_U8);
        send_sample(64'h3FE0_0000_0000_0000);
        send_sample(64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_unused_codes();
        set_formats(FMT_UNUSED5, FMT_FLT);
        send_sample(64'h1234_5678_9ABC_DEF0);
        set_formats(FMT_S16, FMT_UNUSED7);
        send_sample(64'h0000_0000_0000_4000);
    endtask

    task automatic test_all_pairs();
        for (int s = 0; s <= int'(FMT_DBL); s++) begin
            for (int t = 0; t <= int'(FMT_DBL); t++) begin
                set_formats(3'(s), 3'(t));
                sender_busy_mode = ($urandom_range(0, 3) == 0);
                repeat (50) send_sample(random_sample(3'(s)));
                sender_busy_mode = 1'b0;
            end
        end
        set_formats(FMT_UNUSED7, FMT_UNUSED7);
        repeat (10) send_sample(random_sample(FMT_DBL));
        set_formats(FMT_FLT, FMT_UNUSED5);
        repeat (10) send_sample(random_sample(FMT_FLT));
    endtask

    // output held off long enough that the pipeline fills and stalls its input
    task automatic test_output_hold();
        set_formats(FMT_FLT, FMT_S32);
        sender_busy_mode = 1'b1;
        @(negedge i_clk);
        hold_req = 300;
        repeat (150) send_sample(random_sample(FMT_FLT));
        sender_busy_mode = 1'b0;
    endtask

    // ---------------- output side ----------------

    // long hold-off counter
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left <= hold_req;
            hold_req <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver ready with random stalls per word
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n || hold_left > 0) begin
            i_converted_ready <= 1'b0;
        end else if (i_converted_ready && o_converted_valid) begin
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
            i_converted_ready <= (n == 0);
            stall_left <= (n > 0) ? n - 1 : 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_converted_ready <= 1'b0;
        end else begin
            i_converted_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        error_count++;
        $display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
    endtask

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        logic [63:0] want;
        if (i_rst_n && o_converted_valid && i_converted_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 64'd0, o_converted_bits);
            end else begin
                want = expected_words.pop_front();
                if (o_converted_bits !== want)
                    report_mismatch("converted_bits", want, o_converted_bits);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_formats();
        test_float_to_int_corners();
        test_double_corners();
        test_unused_codes();
        test_all_pairs();
        test_output_hold();
        drain();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
